// ===== rtl/core/tqle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tabular Q-learning engine package
// Register indexes, item function codes and fixed-point constants shared by
// the engine.
// ----------------------------------------------------------------------------
package tqle_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_LEARNING_RATE  = 2'd0,
		CFG_DISCOUNT_RATE  = 2'd1,
		CFG_EXPLORE_RATE   = 2'd2,
		CFG_ACTIONS_IN_USE = 2'd3
	} cfg_idx_t;

	// Item function codes
	localparam logic FUNC_SELECT = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// Field widths fixed by the interface
	localparam int CFG_IDX_W  = 2;
	localparam int RATE_W     = 17;
	localparam int ACT_CNT_W  = 4;
	localparam int STATE_W    = 8;
	localparam int ACTION_W   = 3;
	localparam int VALUE_W    = 32;
	localparam int DRAW_W     = 16;

	// A rate of one in unsigned Q1.16
	localparam logic [RATE_W-1:0] RATE_ONE = 17'd65536;

	// Reset values of the configuration registers
	localparam logic [RATE_W-1:0]    LR_RESET      = 17'd6554;
	localparam logic [RATE_W-1:0]    DISC_RESET    = 17'd58982;
	localparam logic [RATE_W-1:0]    EPS_RESET     = 17'd6554;
	localparam logic [ACT_CNT_W-1:0] ACTIONS_RESET = 4'd8;

endpackage : tqle_pkg
`default_nettype wire

// ===== rtl/core/tabular_q_learning_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tabular Q-learning engine
// Holds a Q table of signed Q16.16 values in one on-chip memory and serves
// epsilon-greedy action selection and Q updates, one item at a time. After
// reset the table is cleared by a pass that writes one entry per cycle
// to each of the NUM_STATES * MAX_ACTIONS entries; busy is high
// throughout and start is ignored. An item is taken when start is high and
// busy is low; its single result appears for one cycle with done high and
// must be captured then, as the engine cannot be stalled. An exploring select
// finishes in S_SEL without reading the table. A greedy select scans the
// state's row through the single memory read port, once for the maximum
// and then again until it finds the chosen tie among n actions in use. An
// update scans the next state's row once and then runs the three products
// through one shared multiplier. Configuration writes are always ready and
// must only be issued while idle.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine #(
	parameter int NUM_STATES  = 256,
	parameter int MAX_ACTIONS = 8,
	parameter int Q_WIDTH     = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Item command
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic                                  func,
	input  wire logic [tqle_pkg::STATE_W-1:0]          cur_state,
	input  wire logic [tqle_pkg::ACTION_W-1:0]         taken_action,
	input  wire logic signed [tqle_pkg::VALUE_W-1:0]   reward_value,
	input  wire logic [tqle_pkg::STATE_W-1:0]          next_state,
	input  wire logic [tqle_pkg::DRAW_W-1:0]           explore_draw,
	input  wire logic [tqle_pkg::DRAW_W-1:0]           pick_draw,
	// Result
	output logic                                       done,
	output logic [tqle_pkg::ACTION_W-1:0]              chosen_action,
	output logic                                       explored,
	output logic signed [tqle_pkg::VALUE_W-1:0]        new_q,
	// Configuration write channel
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [tqle_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [tqle_pkg::RATE_W-1:0]           cfg_data
);

	localparam int QW     = (Q_WIDTH < 32) ? Q_WIDTH : 32;
	localparam int SW     = $clog2(NUM_STATES);
	localparam int CW     = $clog2(MAX_ACTIONS);
	localparam int DEPTH  = NUM_STATES * MAX_ACTIONS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int NW     = tqle_pkg::ACT_CNT_W;
	localparam int MA_W   = tqle_pkg::RATE_W + 1;
	localparam int MB_W   = 35;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = 56;
	localparam int PK_W   = tqle_pkg::DRAW_W + NW;

	localparam logic signed [ACC_W-1:0] Q_HI = ACC_W'((64'sd1 <<< (QW - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] Q_LO = -Q_HI - ACC_W'(1);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SEL,
		S_SCAN,
		S_PICK,
		S_FIND,
		S_QRD,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_WR
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [tqle_pkg::RATE_W-1:0]    lr_q, disc_q, eps_q;
	logic [tqle_pkg::ACT_CNT_W-1:0] actions_q;

	// Latched item
	logic                           func_q;
	logic [SW-1:0]                  cur_row_q, nxt_row_q;
	logic [CW-1:0]                  act_q;
	logic signed [tqle_pkg::VALUE_W-1:0] reward_q;
	logic [tqle_pkg::DRAW_W-1:0]    explore_q, pick_q;
	logic [NW-1:0]                  n_q;

	// Row scan
	logic [NW-1:0]                  issue_q;
	logic                           v_s1;
	logic [NW-1:0]                  idx_s1;
	logic signed [QW-1:0]           max_q;
	logic [NW-1:0]                  cnt_q, seen_q, k_q;

	// Arithmetic
	logic signed [QW-1:0]           q_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [MB_W-1:0]         target_q;

	// Memory
	logic signed [QW-1:0]           mem [DEPTH];
	logic signed [QW-1:0]           rdata_q;
	logic [ADDR_W-1:0]              clr_q;

	// Results
	logic                           done_q, explored_q;
	logic [tqle_pkg::ACTION_W-1:0]  chosen_q;
	logic signed [tqle_pkg::VALUE_W-1:0] new_q_q;

	// State and action folding tables
	logic [SW-1:0] st_map  [256];
	logic [CW-1:0] act_map [8];

	for (genvar k = 0; k < 256; k++) begin : g_st_map
		assign st_map[k] = SW'(k % NUM_STATES);
	end
	for (genvar k = 0; k < 8; k++) begin : g_act_map
		assign act_map[k] = CW'(k % MAX_ACTIONS);
	end

	// Effective settings
	logic [tqle_pkg::RATE_W-1:0] lr_eff, disc_eff, eps_eff, lr_inv;
	logic [NW-1:0]               n_eff, n_last;

	always_comb begin
		lr_eff   = (lr_q   > tqle_pkg::RATE_ONE) ? tqle_pkg::RATE_ONE : lr_q;
		disc_eff = (disc_q > tqle_pkg::RATE_ONE) ? tqle_pkg::RATE_ONE : disc_q;
		eps_eff  = (eps_q  > tqle_pkg::RATE_ONE) ? tqle_pkg::RATE_ONE : eps_q;
		lr_inv   = tqle_pkg::RATE_ONE - lr_eff;
		if (actions_q == '0) begin
			n_eff = NW'(1);
		end else if ({3'b000, actions_q} > 7'(MAX_ACTIONS)) begin
			n_eff = NW'(MAX_ACTIONS);
		end else begin
			n_eff = actions_q;
		end
		n_last = n_q - NW'(1);
	end

	logic explore_hit;
	logic [PK_W-1:0] pick_n, pick_cnt;

	assign explore_hit = (eps_eff != '0) && (eps_eff > {1'b0, explore_q});
	assign pick_n      = PK_W'(pick_q) * PK_W'(n_q);
	assign pick_cnt    = PK_W'(pick_q) * PK_W'(cnt_q);

	// Shared multiplier operand selection
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] mul_p;

	always_comb begin
		case (state_q)
			S_QRD: begin
				mul_a = $signed({1'b0, disc_eff});
				mul_b = MB_W'(max_q);
			end
			S_M2: begin
				mul_a = $signed({1'b0, lr_inv});
				mul_b = MB_W'(q_q);
			end
			S_M3: begin
				mul_a = $signed({1'b0, lr_eff});
				mul_b = target_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Rounding toward minus infinity, then saturation to the stored width
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [QW-1:0]    sat_v;

	always_comb begin
		acc_sh = acc_q >>> 16;
		if (acc_sh > Q_HI) begin
			sat_v = Q_HI[QW-1:0];
		end else if (acc_sh < Q_LO) begin
			sat_v = Q_LO[QW-1:0];
		end else begin
			sat_v = acc_sh[QW-1:0];
		end
	end

	// Memory port control
	logic              scan_st, issue_ok, rd_en, wr_en;
	logic [SW-1:0]     rd_row;
	logic [CW-1:0]     rd_col;
	logic [ADDR_W-1:0] rd_addr, upd_addr, wr_addr;
	logic signed [QW-1:0] wr_data;

	always_comb begin
		scan_st  = (state_q == S_SCAN) || (state_q == S_FIND);
		issue_ok = scan_st && (issue_q < n_q);
		rd_en    = issue_ok || (state_q == S_QRD);
		upd_addr = ADDR_W'(ADDR_W'(cur_row_q) * ADDR_W'(MAX_ACTIONS)) + ADDR_W'(act_q);
		if (state_q == S_QRD) begin
			rd_row = cur_row_q;
			rd_col = act_q;
		end else begin
			rd_row = (func_q == tqle_pkg::FUNC_UPDATE) ? nxt_row_q : cur_row_q;
			rd_col = CW'(issue_q);
		end
		rd_addr  = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(MAX_ACTIONS)) + ADDR_W'(rd_col);
		wr_en    = (state_q == S_CLEAR) || (state_q == S_WR);
		wr_addr  = (state_q == S_CLEAR) ? clr_q : upd_addr;
		wr_data  = (state_q == S_CLEAR) ? '0 : sat_v;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q      <= tqle_pkg::LR_RESET;
			disc_q    <= tqle_pkg::DISC_RESET;
			eps_q     <= tqle_pkg::EPS_RESET;
			actions_q <= tqle_pkg::ACTIONS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tqle_pkg::CFG_LEARNING_RATE:  lr_q      <= cfg_data;
				tqle_pkg::CFG_DISCOUNT_RATE:  disc_q    <= cfg_data;
				tqle_pkg::CFG_EXPLORE_RATE:   eps_q     <= cfg_data;
				tqle_pkg::CFG_ACTIONS_IN_USE: actions_q <= cfg_data[NW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			func_q     <= tqle_pkg::FUNC_SELECT;
			cur_row_q  <= '0;
			nxt_row_q  <= '0;
			act_q      <= '0;
			reward_q   <= '0;
			explore_q  <= '0;
			pick_q     <= '0;
			n_q        <= '0;
			issue_q    <= '0;
			v_s1       <= 1'b0;
			idx_s1     <= '0;
			max_q      <= '0;
			cnt_q      <= '0;
			seen_q     <= '0;
			k_q        <= '0;
			q_q        <= '0;
			prod_q     <= '0;
			acc_q      <= '0;
			target_q   <= '0;
			done_q     <= 1'b0;
			explored_q <= 1'b0;
			chosen_q   <= '0;
			new_q_q    <= '0;
		end else begin
			// Reads issued during a scan come back in the next cycle
			if (scan_st) begin
				v_s1   <= issue_ok;
				idx_s1 <= issue_q;
				if (issue_ok) begin
					issue_q <= issue_q + NW'(1);
				end
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end

				// Every result is raised on the way back here, so it lasts one cycle.
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						func_q    <= func;
						cur_row_q <= st_map[cur_state];
						nxt_row_q <= st_map[next_state];
						act_q     <= act_map[taken_action];
						reward_q  <= reward_value;
						explore_q <= explore_draw;
						pick_q    <= pick_draw;
						n_q       <= n_eff;
						issue_q   <= '0;
						v_s1      <= 1'b0;
						state_q   <= (func == tqle_pkg::FUNC_UPDATE) ? S_SCAN : S_SEL;
					end
				end

				S_SEL: begin
					if (explore_hit) begin
						done_q     <= 1'b1;
						explored_q <= 1'b1;
						chosen_q   <= pick_n[tqle_pkg::DRAW_W +: tqle_pkg::ACTION_W];
						new_q_q    <= '0;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end

				// Running maximum of the row and how many entries share it
				S_SCAN: begin
					if (v_s1) begin
						if (idx_s1 == '0 || rdata_q > max_q) begin
							max_q <= rdata_q;
							cnt_q <= NW'(1);
						end else if (rdata_q == max_q) begin
							cnt_q <= cnt_q + NW'(1);
						end
						if (idx_s1 == n_last) begin
							state_q <= (func_q == tqle_pkg::FUNC_UPDATE) ? S_QRD : S_PICK;
						end
					end
				end

				S_PICK: begin
					k_q     <= pick_cnt[tqle_pkg::DRAW_W +: NW];
					seen_q  <= '0;
					issue_q <= '0;
					v_s1    <= 1'b0;
					state_q <= S_FIND;
				end

				// Second pass: stop at the chosen one among the tied maxima
				S_FIND: begin
					if (v_s1 && rdata_q == max_q) begin
						if (seen_q == k_q) begin
							done_q     <= 1'b1;
							explored_q <= 1'b0;
							chosen_q   <= idx_s1[tqle_pkg::ACTION_W-1:0];
							new_q_q    <= '0;
							state_q    <= S_IDLE;
						end else begin
							seen_q <= seen_q + NW'(1);
						end
					end
				end

				S_QRD: begin
					prod_q  <= mul_p;
					state_q <= S_M1;
				end

				S_M1: begin
					q_q     <= rdata_q;
					acc_q   <= (ACC_W'(reward_q) <<< 16) + ACC_W'(prod_q);
					state_q <= S_M2;
				end

				S_M2: begin
					target_q <= MB_W'(acc_q >>> 16);
					prod_q   <= mul_p;
					state_q  <= S_M3;
				end

				S_M3: begin
					acc_q   <= ACC_W'(prod_q);
					prod_q  <= mul_p;
					state_q <= S_M4;
				end

				S_M4: begin
					acc_q   <= acc_q + ACC_W'(prod_q);
					state_q <= S_WR;
				end

				S_WR: begin
					done_q     <= 1'b1;
					explored_q <= 1'b0;
					chosen_q   <= '0;
					new_q_q    <= tqle_pkg::VALUE_W'(sat_v);
					state_q    <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign chosen_action = chosen_q;
	assign explored      = explored_q;
	assign new_q         = new_q_q;

	// A result always leaves the engine ready for the next command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while engine still busy");

	// An accepted command makes the engine busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not occupy the engine");

	// Exploring selections never report an updated value
	a_explore_noq: assert property (@(posedge clk) disable iff (!arst_n)
		(done && explored) |-> (new_q == '0))
		else $error("exploring result carries a Q value");

	// Returned read data always belongs to an action in use
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (idx_s1 < n_q))
		else $error("row scan ran past the actions in use");

	// The chosen tie never lies beyond the number of tied entries
	a_pick_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (k_q < cnt_q))
		else $error("tie pick outside the tied entries");

	// No command is taken before the clearing pass has finished
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> busy)
		else $error("engine idle during clearing pass");

endmodule : tabular_q_learning_engine
`default_nettype wire

// ===== dv/tqle_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Q-learning engine result checker
// Watches the item, result and register channels of the engine, keeps its own
// copy of the Q table and the registers, works out the result of every
// accepted item and compares each result field by field, oldest first.
// ----------------------------------------------------------------------------
module tqle_result_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic                                  busy,
	input  wire logic                                  func,
	input  wire logic [tqle_pkg::STATE_W-1:0]          cur_state,
	input  wire logic [tqle_pkg::ACTION_W-1:0]         taken_action,
	input  wire logic signed [tqle_pkg::VALUE_W-1:0]   reward_value,
	input  wire logic [tqle_pkg::STATE_W-1:0]          next_state,
	input  wire logic [tqle_pkg::DRAW_W-1:0]           explore_draw,
	input  wire logic [tqle_pkg::DRAW_W-1:0]           pick_draw,
	input  wire logic                                  done,
	input  wire logic [tqle_pkg::ACTION_W-1:0]         chosen_action,
	input  wire logic                                  explored,
	input  wire logic signed [tqle_pkg::VALUE_W-1:0]   new_q,
	input  wire logic                                  cfg_valid,
	input  wire logic                                  cfg_ready,
	input  wire logic [tqle_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [tqle_pkg::RATE_W-1:0]           cfg_data,
	output int unsigned                                mismatch_count,
	output int unsigned                                outstanding
);

	localparam int     ROW_LEN     = 8;
	localparam int     TABLE_DEPTH = 256 * ROW_LEN;
	localparam longint Q_MAX       = 64'sd2147483647;
	localparam longint Q_MIN       = -64'sd2147483648;

	typedef struct packed {
		logic [tqle_pkg::ACTION_W-1:0]       action;
		logic                                explored;
		logic signed [tqle_pkg::VALUE_W-1:0] q_value;
	} outcome_t;

	logic signed [tqle_pkg::VALUE_W-1:0] q_table [TABLE_DEPTH];
	logic [tqle_pkg::RATE_W-1:0]         lr_reg, disc_reg, eps_reg;
	logic [tqle_pkg::ACT_CNT_W-1:0]      act_reg;
	outcome_t                            awaited_results [$];

	function automatic longint clamped_rate(logic [tqle_pkg::RATE_W-1:0] v);
		return (v > tqle_pkg::RATE_ONE) ? longint'(tqle_pkg::RATE_ONE) : longint'(v);
	endfunction

	function automatic longint row_peak(int unsigned base, longint n);
		longint peak;
		peak = q_table[base];
		for (int i = 1; i < n; i++)
			if (q_table[base + i] > peak)
				peak = q_table[base + i];
		return peak;
	endfunction

	// Works out the result of one item and applies any table write it makes.
	function automatic outcome_t engine_outcome(logic fn,
			logic [tqle_pkg::STATE_W-1:0] st, logic [tqle_pkg::ACTION_W-1:0] act,
			logic signed [tqle_pkg::VALUE_W-1:0] rwd, logic [tqle_pkg::STATE_W-1:0] nst,
			logic [tqle_pkg::DRAW_W-1:0] xdraw, logic [tqle_pkg::DRAW_W-1:0] pdraw);
		outcome_t    res;
		longint      n, eps, lr, disc, peak, target, blend;
		int unsigned base, entry, cnt;
		int unsigned ties [ROW_LEN];
		res = '0;
		n = (act_reg == 0) ? 1 : (act_reg > ROW_LEN) ? ROW_LEN : act_reg;
		if (fn == tqle_pkg::FUNC_SELECT) begin
			base = st * ROW_LEN;
			eps = clamped_rate(eps_reg);
			if (eps > 0 && eps > xdraw) begin
				res.action = tqle_pkg::ACTION_W'((longint'(pdraw) * n) >> 16);
				res.explored = 1'b1;
			end else begin
				// Ties for the row maximum are numbered in action order.
				peak = row_peak(base, n);
				cnt = 0;
				for (int i = 0; i < n; i++)
					if (q_table[base + i] == peak) begin
						ties[cnt] = i;
						cnt++;
					end
				res.action = tqle_pkg::ACTION_W'(ties[(longint'(pdraw) * cnt) >> 16]);
			end
		end else begin
			entry = st * ROW_LEN + act;
			base = nst * ROW_LEN;
			lr = clamped_rate(lr_reg);
			disc = clamped_rate(disc_reg);
			peak = row_peak(base, n);
			// Arithmetic shifts give the floor of both divisions by 65536.
			target = (longint'(rwd) * 65536 + disc * peak) >>> 16;
			blend = ((65536 - lr) * longint'(q_table[entry]) + lr * target) >>> 16;
			if (blend > Q_MAX)
				blend = Q_MAX;
			if (blend < Q_MIN)
				blend = Q_MIN;
			q_table[entry] = blend[31:0];
			res.q_value = blend[31:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, longint seen, longint wanted);
		$display("%0t ns: mismatch on %s: got %0d, wanted %0d", $time, what, seen, wanted);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				q_table[i] = '0;
			lr_reg = tqle_pkg::LR_RESET;
			disc_reg = tqle_pkg::DISC_RESET;
			eps_reg = tqle_pkg::EPS_RESET;
			act_reg = tqle_pkg::ACTIONS_RESET;
			awaited_results.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (tqle_pkg::cfg_idx_t'(cfg_index))
					tqle_pkg::CFG_LEARNING_RATE:  lr_reg = cfg_data;
					tqle_pkg::CFG_DISCOUNT_RATE:  disc_reg = cfg_data;
					tqle_pkg::CFG_EXPLORE_RATE:   eps_reg = cfg_data;
					tqle_pkg::CFG_ACTIONS_IN_USE: act_reg = cfg_data[tqle_pkg::ACT_CNT_W-1:0];
					default: ;
				endcase
			end
			// A result may end its cycle at the same edge as the next transfer in.
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no item outstanding", 1, 0);
				end else begin
					want = awaited_results.pop_front();
					if (chosen_action !== want.action)
						report_mismatch("chosen_action", chosen_action, want.action);
					if (explored !== want.explored)
						report_mismatch("explored", explored, want.explored);
					if (new_q !== want.q_value)
						report_mismatch("new_q", new_q, want.q_value);
				end
			end
			if (start && !busy)
				awaited_results = {awaited_results, engine_outcome(func, cur_state,
					taken_action, reward_value, next_state, explore_draw, pick_draw)};
			outstanding = awaited_results.size();
		end
	end

endmodule

// ===== dv/tabular_q_learning_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Q-learning engine testbench
// Drives directed and random select and update items into the engine under a
// series of register settings, with random sender gaps, and lets the result
// checker compare every result against its own prediction.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine_test;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic                                func;
	logic [tqle_pkg::STATE_W-1:0]        cur_state;
	logic [tqle_pkg::ACTION_W-1:0]       taken_action;
	logic signed [tqle_pkg::VALUE_W-1:0] reward_value;
	logic [tqle_pkg::STATE_W-1:0]        next_state;
	logic [tqle_pkg::DRAW_W-1:0]         explore_draw;
	logic [tqle_pkg::DRAW_W-1:0]         pick_draw;
	logic                                done;
	logic [tqle_pkg::ACTION_W-1:0]       chosen_action;
	logic                                explored;
	logic signed [tqle_pkg::VALUE_W-1:0] new_q;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [tqle_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [tqle_pkg::RATE_W-1:0]         cfg_data;
	int unsigned                         mismatch_count;
	int unsigned                         outstanding;

	int unsigned selects_sent, updates_sent, settings_applied, steady_left;

	tabular_q_learning_engine dut (.*);
	tqle_result_checker checker_i (.*);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tabular_q_learning_engine_test: errors");
		$finish;
	end

	// All tasks below are entered and left at a falling edge.
	task automatic send_item(logic fn, logic [tqle_pkg::STATE_W-1:0] st,
			logic [tqle_pkg::ACTION_W-1:0] act, logic signed [tqle_pkg::VALUE_W-1:0] rwd,
			logic [tqle_pkg::STATE_W-1:0] nst, logic [tqle_pkg::DRAW_W-1:0] xdraw,
			logic [tqle_pkg::DRAW_W-1:0] pdraw);
		start = 1'b1;
		func = fn;
		cur_state = st;
		taken_action = act;
		reward_value = rwd;
		next_state = nst;
		explore_draw = xdraw;
		pick_draw = pdraw;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		if (fn == tqle_pkg::FUNC_SELECT)
			selects_sent++;
		else
			updates_sent++;
	endtask

	task automatic wait_until_quiet();
		start = 1'b0;
		while (outstanding != 0 || busy)
			@(negedge clk);
	endtask

	task automatic hold_sender();
		int unsigned gap, roll;
		roll = $urandom_range(0, 99);
		if (steady_left > 0) begin
			steady_left--;
			gap = 0;
		end else if (roll < 3) begin
			steady_left = $urandom_range(15, 40);
			gap = 0;
		end else if (roll < 55) begin
			gap = 0;
		end else if (roll < 88) begin
			gap = $urandom_range(1, 3);
		end else if (roll < 97) begin
			gap = $urandom_range(4, 12);
		end else begin
			gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		if ($urandom_range(0, 149) == 0)
			wait_until_quiet();
	endtask

	task automatic write_register(tqle_pkg::cfg_idx_t idx,
			logic [tqle_pkg::RATE_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_settings(logic [tqle_pkg::RATE_W-1:0] lr,
			logic [tqle_pkg::RATE_W-1:0] disc, logic [tqle_pkg::RATE_W-1:0] eps,
			logic [tqle_pkg::RATE_W-1:0] acts);
		wait_until_quiet();
		write_register(tqle_pkg::CFG_LEARNING_RATE, lr);
		write_register(tqle_pkg::CFG_DISCOUNT_RATE, disc);
		write_register(tqle_pkg::CFG_EXPLORE_RATE, eps);
		write_register(tqle_pkg::CFG_ACTIONS_IN_USE, acts);
		settings_applied++;
	endtask

	function automatic logic [tqle_pkg::RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return tqle_pkg::RATE_ONE;
			2:       return tqle_pkg::RATE_W'($urandom_range(65537, 131071));
			default: return tqle_pkg::RATE_W'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [tqle_pkg::RATE_W-1:0] pick_action_count();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return tqle_pkg::RATE_W'(8);
			2:       return tqle_pkg::RATE_W'($urandom_range(9, 15));
			default: return tqle_pkg::RATE_W'($urandom_range(1, 8));
		endcase
	endfunction

	// Most items stay in a few states so that updates build on one another.
	function automatic logic [tqle_pkg::STATE_W-1:0] pick_state();
		if ($urandom_range(0, 4) != 0)
			return tqle_pkg::STATE_W'($urandom_range(0, 7));
		return tqle_pkg::STATE_W'($urandom_range(0, 255));
	endfunction

	task automatic random_item();
		logic                                fn;
		logic [tqle_pkg::STATE_W-1:0]        st, nst;
		logic signed [tqle_pkg::VALUE_W-1:0] rwd;
		fn = 1'($urandom_range(0, 1));
		st = pick_state();
		nst = pick_state();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: rwd = (int'($urandom_range(0, 8)) - 4) * 65536;
			4, 5:       rwd = int'($urandom_range(0, 524287)) - 262144;
			6, 7:       rwd = $urandom;
			8:          rwd = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default:    rwd = '0;
		endcase
		send_item(fn, st, tqle_pkg::ACTION_W'($urandom_range(0, 7)), rwd, nst,
			tqle_pkg::DRAW_W'($urandom_range(0, 65535)),
			tqle_pkg::DRAW_W'($urandom_range(0, 65535)));
		hold_sender();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = tqle_pkg::FUNC_SELECT;
		cur_state = '0;
		taken_action = '0;
		reward_value = '0;
		next_state = '0;
		explore_draw = '0;
		pick_draw = '0;
		cfg_valid = 1'b0;
		cfg_index = tqle_pkg::CFG_LEARNING_RATE;
		cfg_data = '0;
		selects_sent = 0;
		updates_sent = 0;
		settings_applied = 0;
		steady_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		wait_until_quiet();

		// Reset register values: greedy ties on a cleared row, exploring at
		// both ends of the draw, the explore boundary and the reward extremes.
		send_item(tqle_pkg::FUNC_SELECT, 0, 0, 0, 0, 16'hFFFF, 16'h0000);
		send_item(tqle_pkg::FUNC_SELECT, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
		send_item(tqle_pkg::FUNC_SELECT, 255, 0, 0, 0, 16'h0000, 16'hFFFF);
		send_item(tqle_pkg::FUNC_SELECT, 255, 0, 0, 0, 16'd6553, 16'd32768);
		send_item(tqle_pkg::FUNC_SELECT, 255, 0, 0, 0, 16'd6554, 16'd32768);
		send_item(tqle_pkg::FUNC_UPDATE, 255, 7, 32'sh7FFFFFFF, 255, 0, 0);
		send_item(tqle_pkg::FUNC_UPDATE, 255, 0, 32'sh80000000, 0, 0, 0);
		send_item(tqle_pkg::FUNC_SELECT, 255, 0, 0, 0, 16'hFFFF, 16'h0000);

		// Full learning and discount with no exploring: the second update of
		// the same entry saturates high, and a zero draw stays greedy.
		apply_settings(tqle_pkg::RATE_ONE, tqle_pkg::RATE_ONE, 0, 8);
		send_item(tqle_pkg::FUNC_UPDATE, 1, 0, 32'sh7FFFFFFF, 1, 0, 0);
		send_item(tqle_pkg::FUNC_UPDATE, 1, 0, 32'sh7FFFFFFF, 1, 0, 0);
		send_item(tqle_pkg::FUNC_SELECT, 0, 0, 0, 0, 16'h0000, 16'h0000);

		// Rates above one act as one and an action count of zero as one; the
		// second update saturates low and one update hits an unused action.
		apply_settings(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 0);
		send_item(tqle_pkg::FUNC_UPDATE, 2, 0, 32'sh80000000, 2, 0, 0);
		send_item(tqle_pkg::FUNC_UPDATE, 2, 0, 32'sh80000000, 2, 0, 0);
		send_item(tqle_pkg::FUNC_UPDATE, 4, 5, 32'sh00030000, 4, 0, 0);
		send_item(tqle_pkg::FUNC_SELECT, 4, 0, 0, 0, 16'hFFFF, 16'hFFFF);

		// No learning, certain exploring and an action count above the table.
		apply_settings(0, 0, tqle_pkg::RATE_ONE, 15);
		send_item(tqle_pkg::FUNC_UPDATE, 1, 0, 32'sh00050000, 1, 0, 0);
		send_item(tqle_pkg::FUNC_SELECT, 1, 0, 0, 0, 16'hFFFF, 16'd12345);

		// Smallest non-zero rates and three actions in use.
		apply_settings(1, 1, 1, 3);
		send_item(tqle_pkg::FUNC_SELECT, 1, 0, 0, 0, 16'h0000, 16'hFFFF);
		send_item(tqle_pkg::FUNC_SELECT, 1, 0, 0, 0, 16'h0001, 16'hFFFF);
		send_item(tqle_pkg::FUNC_UPDATE, 3, 6, 32'shFFFFFFFF, 255, 0, 0);
		send_item(tqle_pkg::FUNC_UPDATE, 0, 4, 32'sh00010000, 1, 0, 0);
		hold_sender();

		for (int phase = 0; phase < 6; phase++) begin
			apply_settings(pick_rate(), pick_rate(), pick_rate(), pick_action_count());
			for (int k = 0; k < 125; k++)
				random_item();
		end

		wait_until_quiet();
		repeat (40) @(posedge clk);
		$display("Covered %0d selects and %0d updates under %0d register settings,",
			selects_sent, updates_sent, settings_applied + 1);
		$display("including saturation, tied maxima and out-of-range register values.");
		if (mismatch_count == 0)
			$display("tabular_q_learning_engine_test: clean");
		else
			$display("tabular_q_learning_engine_test: errors");
		$finish;
	end

endmodule
